### rtl/hhlp_pkg.sv
// Package for the HTTP header line parser: character codes, result kinds,
// line error causes and the character class record.
// No dependencies.
`default_nettype none

package hhlp_pkg;

  localparam int PEND_DEPTH = 31;
  localparam int PEND_CNT_W = $clog2(PEND_DEPTH + 1);
  localparam int PEND_IDX_W = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;

  localparam logic [7:0] CHR_HT    = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_VT    = 8'h0B;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SP    = 8'h20;
  localparam logic [7:0] CHR_COLON = 8'h3A;

  localparam logic [1:0] KIND_NAME   = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  localparam logic [2:0] CAUSE_OK       = 3'd0;
  localparam logic [2:0] CAUSE_NO_COLON = 3'd1;
  localparam logic [2:0] CAUSE_EMPTY    = 3'd2;
  localparam logic [2:0] CAUSE_WS_COLON = 3'd3;
  localparam logic [2:0] CAUSE_BAD_NAME = 3'd4;

  typedef struct packed {
    logic       tchar;
    logic       cspace;
    logic       trim;
    logic [7:0] lower;
  } char_class_t;

endpackage

`default_nettype wire

### rtl/hhlp_classify.sv
// Character classifier shared by every content step of the parser.
// Depends on hhlp_pkg for the character codes and the class record.
`default_nettype none

module hhlp_classify
  import hhlp_pkg::*;
(
  input  wire logic [7:0]  chr,
  output char_class_t      cls
);

  logic alnum;
  logic sym;

  always_comb begin
    alnum = ((chr >= 8'h61) && (chr <= 8'h7A)) || ((chr >= 8'h41) && (chr <= 8'h5A)) ||
            ((chr >= 8'h30) && (chr <= 8'h39));
    case (chr)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
      8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: sym = 1'b1;
      default: sym = 1'b0;
    endcase
    cls.tchar  = alnum || sym;
    cls.cspace = (chr == CHR_SP) || ((chr >= CHR_HT) && (chr <= CHR_CR));
    cls.trim   = (chr == CHR_SP) || (chr == CHR_HT) || (chr == CHR_VT) ||
                 (chr == CHR_CR) || (chr == CHR_LF);
    cls.lower  = ((chr >= 8'h41) && (chr <= 8'h5A)) ? (chr + 8'd32) : chr;
  end

endmodule

`default_nettype wire

### rtl/http_header_line_parser_unit.sv
// Top level of the HTTP header line parser: byte sequencer, held whitespace
// memory and output register. Depends on hhlp_pkg and hhlp_classify.
//
// Raw header bytes enter on the in_ stream, one request per byte. Each byte
// yields zero or more results on the out_ stream: lowercased name bytes,
// value bytes, one status per line with its error cause, or an end-of-block
// marker for an empty line. out_tlast marks the final result of a byte.
// The sequencer takes the byte, then serves the held CR slot, then the byte
// itself, and in_tready stays low until it is back in idle. An LF that
// completes a CRLF ends the line at the held CR slot. Trailing whitespace
// inside a value is held in a small memory; when a later value byte
// arrives, the held bytes are replayed one per cycle while the receiver
// accepts them, before that byte is emitted.
// Results leave through a single output register. While the receiver
// stalls, the sequencer waits at the next result it has to emit, and no new
// byte is accepted. The register is freed by the receiver in the same cycle
// a new result is loaded.
// Reset clears the line state, the held CR and the output valid flag.
`default_nettype none

module http_header_line_parser_unit
  import hhlp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] out_byte, [10:8] error_cause, rest zero
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast   // last
);

  typedef enum logic [1:0] {PH_NAME, PH_SKIP, PH_BODY} phase_t;
  typedef enum logic [1:0] {ST_IDLE, ST_A, ST_B, ST_FLUSH} state_t;

  state_t                 state_r, state_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [7:0]             byte_r, byte_nxt;
  logic                   cr_held_r, cr_held_nxt;
  logic                   name_seen_r, name_seen_nxt;
  logic                   name_bad_r, name_bad_nxt;
  logic                   prev_space_r, prev_space_nxt;
  logic [PEND_CNT_W-1:0]  pend_cnt_r, pend_cnt_nxt;
  logic                   pend_ovf_r, pend_ovf_nxt;
  logic [PEND_IDX_W-1:0]  flush_idx_r, flush_idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_byte_r, out_byte_nxt;
  logic [2:0]             out_cause_r, out_cause_nxt;
  logic [1:0]             out_kind_r, out_kind_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [7:0]             pend_mem [PEND_DEPTH];
  logic [7:0]             rd_data_r;
  logic                   mem_we;

  logic [7:0]             cur_b;
  char_class_t            cls;
  logic                   can_emit;
  logic                   want;
  logic [1:0]             e_kind;
  logic [7:0]             e_byte;
  logic [2:0]             e_cause;
  logic                   e_last;
  logic                   content_go;
  logic                   last_flag;
  state_t                 done_state;

  assign cur_b = (state_r == ST_A) ? CHR_CR : byte_r;

  hhlp_classify u_classify (
    .chr (cur_b),
    .cls (cls)
  );

  assign can_emit   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_cause_r, out_byte_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    byte_nxt       = byte_r;
    cr_held_nxt    = cr_held_r;
    name_seen_nxt  = name_seen_r;
    name_bad_nxt   = name_bad_r;
    prev_space_nxt = prev_space_r;
    pend_cnt_nxt   = pend_cnt_r;
    pend_ovf_nxt   = pend_ovf_r;
    flush_idx_nxt  = flush_idx_r;
    mem_we         = 1'b0;
    want           = 1'b0;
    e_kind         = KIND_NAME;
    e_byte         = 8'd0;
    e_cause        = CAUSE_OK;
    e_last         = 1'b0;

    content_go = ((state_r == ST_A) && cr_held_r && (byte_r != CHR_LF)) ||
                 ((state_r == ST_B) && (byte_r != CHR_CR));
    done_state = (state_r == ST_A) ? ST_B : ST_IDLE;
    last_flag  = (state_r == ST_A) ? ((byte_r == CHR_CR) || (byte_r == CHR_COLON)) : 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          byte_nxt  = in_tdata;
          state_nxt = ST_A;
        end
      end
      ST_A: begin
        if (!cr_held_r) begin
          state_nxt = ST_B;
        end else if (byte_r == CHR_LF) begin
          want   = 1'b1;
          e_last = 1'b1;
          if ((phase_r == PH_NAME) && !name_seen_r) begin
            e_kind = KIND_END;
          end else begin
            e_kind = KIND_STATUS;
            if (phase_r == PH_NAME) begin
              e_cause = CAUSE_NO_COLON;
            end else if (!name_seen_r) begin
              e_cause = CAUSE_EMPTY;
            end else if (prev_space_r) begin
              e_cause = CAUSE_WS_COLON;
            end else if (name_bad_r || pend_ovf_r) begin
              e_cause = CAUSE_BAD_NAME;
            end
          end
          if (can_emit) begin
            phase_nxt      = PH_NAME;
            name_seen_nxt  = 1'b0;
            name_bad_nxt   = 1'b0;
            prev_space_nxt = 1'b0;
            pend_cnt_nxt   = '0;
            pend_ovf_nxt   = 1'b0;
            cr_held_nxt    = 1'b0;
            state_nxt      = ST_IDLE;
          end
        end
      end
      ST_B: begin
        if (byte_r == CHR_CR) begin
          cr_held_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        want       = 1'b1;
        e_kind     = KIND_VALUE;
        e_byte     = rd_data_r;
        if (can_emit) begin
          if (PEND_CNT_W'(flush_idx_r) == (pend_cnt_r - PEND_CNT_W'(1))) begin
            pend_cnt_nxt = '0;
            state_nxt    = ST_B;
          end else begin
            flush_idx_nxt = flush_idx_r + PEND_IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (content_go) begin
      case (phase_r)
        PH_NAME: begin
          if (cur_b == CHR_COLON) begin
            phase_nxt = PH_SKIP;
            state_nxt = done_state;
          end else begin
            want   = 1'b1;
            e_kind = KIND_NAME;
            e_byte = cls.lower;
            e_last = last_flag;
            if (can_emit) begin
              name_seen_nxt  = 1'b1;
              name_bad_nxt   = name_bad_r || !cls.tchar;
              prev_space_nxt = cls.cspace;
              state_nxt      = done_state;
            end
          end
        end
        PH_SKIP: begin
          if (cls.trim) begin
            state_nxt = done_state;
          end else begin
            want   = 1'b1;
            e_kind = KIND_VALUE;
            e_byte = cur_b;
            e_last = last_flag;
            if (can_emit) begin
              phase_nxt = PH_BODY;
              state_nxt = done_state;
            end
          end
        end
        default: begin
          if (cls.trim) begin
            if (pend_cnt_r < PEND_CNT_W'(PEND_DEPTH)) begin
              mem_we       = 1'b1;
              pend_cnt_nxt = pend_cnt_r + PEND_CNT_W'(1);
            end else begin
              pend_ovf_nxt = 1'b1;
            end
            state_nxt = done_state;
          end else if (pend_cnt_r == '0) begin
            want   = 1'b1;
            e_kind = KIND_VALUE;
            e_byte = cur_b;
            e_last = last_flag;
            if (can_emit) begin
              state_nxt = done_state;
            end
          end else begin
            flush_idx_nxt = '0;
            state_nxt     = ST_FLUSH;
          end
        end
      endcase
    end

    if ((state_r == ST_A) && (state_nxt == ST_B)) begin
      cr_held_nxt = 1'b0;
    end

    if (want && can_emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = e_byte;
      out_cause_nxt = e_cause;
      out_kind_nxt  = e_kind;
      out_last_nxt  = e_last;
    end else begin
      out_valid_nxt = out_valid_r && !out_tready;
      out_byte_nxt  = out_byte_r;
      out_cause_nxt = out_cause_r;
      out_kind_nxt  = out_kind_r;
      out_last_nxt  = out_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pend_mem[pend_cnt_r[PEND_IDX_W-1:0]] <= cur_b;
    end
    rd_data_r <= pend_mem[flush_idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_NAME;
      cr_held_r    <= 1'b0;
      name_seen_r  <= 1'b0;
      name_bad_r   <= 1'b0;
      prev_space_r <= 1'b0;
      pend_cnt_r   <= '0;
      pend_ovf_r   <= 1'b0;
      flush_idx_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      cr_held_r    <= cr_held_nxt;
      name_seen_r  <= name_seen_nxt;
      name_bad_r   <= name_bad_nxt;
      prev_space_r <= prev_space_nxt;
      pend_cnt_r   <= pend_cnt_nxt;
      pend_ovf_r   <= pend_ovf_nxt;
      flush_idx_r  <= flush_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    byte_r      <= byte_nxt;
    out_byte_r  <= out_byte_nxt;
    out_cause_r <= out_cause_nxt;
    out_kind_r  <= out_kind_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

`default_nettype wire

### sim/tb_http_header_line_parser_unit.sv
// Testbench for http_header_line_parser_unit: drives header bytes on the in_ stream and
// checks every result on the out_ stream against a cycle-free predictor of the parser.
// Depends on hhlp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module tb_http_header_line_parser_unit;
  import hhlp_pkg::*;

  localparam logic [7:0] CHR_FF = 8'h0C;
  localparam int RANDOM_BYTES = 265;
  localparam int SETTLE_CYCLES = 60;

  typedef enum logic [1:0] {AT_NAME, VALUE_SKIP, VALUE_BODY} line_phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] cause;
    logic       last;
  } field_result_t;

  class header_field_predictor;
    line_phase_t   phase;
    bit            cr_held;
    bit            name_seen;
    bit            name_bad;
    bit            prev_name_space;
    bit            held_overflow;
    logic [7:0]    held_ws[PEND_DEPTH];
    int            held_cnt;
    field_result_t byte_results[$];
    field_result_t expected_results[$];
    int            mismatches;
    int            kind_count[4];

    function new();
      cr_held = 1'b0;
      mismatches = 0;
      foreach (kind_count[k]) kind_count[k] = 0;
      clear_line();
    endfunction

    function void clear_line();
      phase = AT_NAME;
      name_seen = 1'b0;
      name_bad = 1'b0;
      prev_name_space = 1'b0;
      held_cnt = 0;
      held_overflow = 1'b0;
    endfunction

    function void emit(logic [1:0] kind, logic [7:0] data, logic [2:0] cause);
      field_result_t r;
      r.kind = kind;
      r.data = data;
      r.cause = cause;
      r.last = 1'b0;
      byte_results.push_back(r);
    endfunction

    function bit is_tchar(logic [7:0] b);
      if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9"))
        return 1'b1;
      case (b)
        8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2D, 8'h2E,
        8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function bit is_trim(logic [7:0] b);
      return b == CHR_SP || b == CHR_HT || b == CHR_VT || b == CHR_CR || b == CHR_LF;
    endfunction

    function void take_content(logic [7:0] b);
      int i;
      case (phase)
        AT_NAME: begin
          if (b == CHR_COLON) begin
            phase = VALUE_SKIP;
          end else begin
            name_seen = 1'b1;
            if (!is_tchar(b)) name_bad = 1'b1;
            prev_name_space = (b == CHR_SP) || (b >= CHR_HT && b <= CHR_CR);
            emit(KIND_NAME, (b >= "A" && b <= "Z") ? b + 8'd32 : b, CAUSE_OK);
          end
        end
        VALUE_SKIP: begin
          if (!is_trim(b)) begin
            phase = VALUE_BODY;
            emit(KIND_VALUE, b, CAUSE_OK);
          end
        end
        default: begin
          if (is_trim(b)) begin
            if (held_cnt < PEND_DEPTH) begin
              held_ws[held_cnt] = b;
              held_cnt++;
            end else begin
              held_overflow = 1'b1;
            end
          end else begin
            for (i = 0; i < held_cnt; i++) emit(KIND_VALUE, held_ws[i], CAUSE_OK);
            held_cnt = 0;
            emit(KIND_VALUE, b, CAUSE_OK);
          end
        end
      endcase
    endfunction

    function void close_line();
      logic [2:0] cause;
      if (phase == AT_NAME && !name_seen) begin
        emit(KIND_END, 8'h00, CAUSE_OK);
      end else begin
        if (phase == AT_NAME) cause = CAUSE_NO_COLON;
        else if (!name_seen) cause = CAUSE_EMPTY;
        else if (prev_name_space) cause = CAUSE_WS_COLON;
        else if (name_bad || held_overflow) cause = CAUSE_BAD_NAME;
        else cause = CAUSE_OK;
        emit(KIND_STATUS, 8'h00, cause);
      end
      clear_line();
    endfunction

    function void accept_byte(logic [7:0] b);
      bit ended;
      field_result_t tail;
      byte_results.delete();
      ended = 1'b0;
      if (cr_held) begin
        cr_held = 1'b0;
        if (b == CHR_LF) begin
          close_line();
          ended = 1'b1;
        end else begin
          take_content(CHR_CR);
        end
      end
      if (!ended) begin
        if (b == CHR_CR) cr_held = 1'b1;
        else take_content(b);
      end
      if (byte_results.size() > 0) begin
        tail = byte_results.pop_back();
        tail.last = 1'b1;
        byte_results.push_back(tail);
      end
      foreach (byte_results[i]) expected_results.push_back(byte_results[i]);
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [15:0] tdata, logic last);
      field_result_t want;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: kind %0d, byte 0x%02h", kind, tdata[7:0]);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      kind_count[want.kind]++;
      if ($isunknown({kind, tdata, last})) begin
        $error("result carries unknown bits: kind %b, data %b, last %b", kind, tdata, last);
        mismatches++;
        return;
      end
      compare_field("kind", want.kind, kind);
      compare_field("out_byte", want.data, tdata[7:0]);
      compare_field("error_cause", want.cause, tdata[10:8]);
      compare_field("tdata padding", 0, tdata[15:11]);
      compare_field("last", want.last, last);
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  header_field_predictor predictor = new();
  int sent_bytes = 0;
  bit sender_calm = 1'b0;

  http_header_line_parser_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_name_char();
    string chars;
    chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789!#$%&'*+-.^_|~";
    if ($urandom_range(0, 39) == 0) return 8'h60;
    return chars[$urandom_range(0, chars.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_value_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CHR_SP || b == CHR_HT || b == CHR_VT || b == CHR_CR || b == CHR_LF);
    return b;
  endfunction

  function automatic logic [7:0] pick_ws(bit plain);
    case ($urandom_range(0, plain ? 2 : 5))
      0: return CHR_SP;
      1: return CHR_HT;
      2: return CHR_VT;
      3: return CHR_CR;
      4: return CHR_LF;
      default: return CHR_FF;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk);
    while (!in_tready);
    predictor.accept_byte(b);
    sent_bytes++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_crlf();
    send_byte(CHR_CR);
    send_byte(CHR_LF);
  endtask

  task automatic send_random_line();
    int r;
    int name_len;
    int tokens;
    int run_len;
    int i;
    int j;
    r = $urandom_range(0, 99);
    sender_calm = ($urandom_range(0, 6) == 0);
    if (r < 6) begin
      send_crlf();
      return;
    end
    if (r < 12) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 1) send_crlf();
      return;
    end
    name_len = ($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, 8);
    for (i = 0; i < name_len; i++) begin
      if ($urandom_range(0, 24) == 0) send_byte(8'($urandom_range(0, 255)));
      else send_byte(pick_name_char());
    end
    if ($urandom_range(0, 19) == 0) send_byte(pick_ws(1'b0));
    if ($urandom_range(0, 24) != 0) send_byte(CHR_COLON);
    repeat ($urandom_range(0, 3)) send_byte(pick_ws(1'b1));
    tokens = $urandom_range(0, 4);
    for (i = 0; i < tokens; i++) begin
      if (i > 0) begin
        run_len = ($urandom_range(0, 29) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 3);
        for (j = 0; j < run_len; j++)
          send_byte(pick_ws(run_len > 3 || $urandom_range(0, 9) != 0));
      end
      repeat ($urandom_range(1, 6)) send_byte(pick_value_char());
    end
    repeat ($urandom_range(0, 3)) send_byte(pick_ws(1'b1));
    r = $urandom_range(0, 19);
    if (r == 0) send_byte(CHR_CR);
    else if (r == 1) send_byte(CHR_LF);
    else send_crlf();
  endtask

  initial begin : receiver
    int hold_left;
    int cycle_cnt;
    bit calm;
    hold_left = 0;
    cycle_cnt = 0;
    calm = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        predictor.check_result(out_tuser, out_tdata, out_tlast);
      cycle_cnt++;
      // A long hold-off early in the run lets the parser fill up and stall its input.
      if (cycle_cnt == 400) hold_left = 250;
      else if (hold_left == 0 && !calm && $urandom_range(0, 99) < 30) hold_left = pick_gap();
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      if ($urandom_range(0, 199) == 0) calm = !calm;
    end
  end

  initial begin : stimulus
    int random_start;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("Host: Example.COM");
    send_crlf();
    send_text("X-Tok:");
    send_byte(CHR_HT);
    send_text(" a ");
    send_byte(CHR_VT);
    send_byte(CHR_HT);
    send_text("b ");
    send_byte(CHR_HT);
    send_crlf();
    send_text(":v");
    send_crlf();
    send_text("nocolon");
    send_crlf();
    send_text("Bad Name: x");
    send_crlf();
    send_text("ab :x");
    send_crlf();
    send_text("a");
    send_byte(CHR_FF);
    send_text(":x");
    send_crlf();
    // A lone CR inside the name and another inside the value.
    send_text("n");
    send_byte(CHR_CR);
    send_text("m:b");
    send_byte(CHR_CR);
    send_text("c");
    send_crlf();
    send_text("a:x");
    send_byte(CHR_LF);
    send_text("y");
    send_crlf();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHR_COLON);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_crlf();
    send_text("o:a");
    repeat (PEND_DEPTH + 3) send_byte(CHR_SP);
    send_text("b");
    send_crlf();
    send_text("t:z");
    repeat (PEND_DEPTH + 4) send_byte(CHR_HT);
    send_crlf();
    send_crlf();
    send_byte(CHR_CR);
    send_crlf();
    send_crlf();

    random_start = sent_bytes;
    while (sent_bytes - random_start < RANDOM_BYTES) send_random_line();
    sender_calm = 1'b0;
    in_tvalid <= 1'b0;

    while (predictor.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d header bytes (directed lines, then random well-formed and broken lines).",
             sent_bytes);
    $display("Checked %0d name bytes, %0d value bytes, %0d line statuses, %0d end markers.",
             predictor.kind_count[KIND_NAME], predictor.kind_count[KIND_VALUE],
             predictor.kind_count[KIND_STATUS], predictor.kind_count[KIND_END]);
    if (predictor.mismatches == 0 && predictor.expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("Timeout with %0d results still expected.", predictor.expected_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### filelist.f
rtl/hhlp_pkg.sv
rtl/hhlp_classify.sv
rtl/http_header_line_parser_unit.sv
sim/tb_http_header_line_parser_unit.sv
